// ===== sv/rmq_pkg.sv =====
package rmq_pkg;

  localparam int DATA_W = 16;
  localparam int FRAC_BITS_DEF = 14;
  // input item width (9 x 16 bits)
  localparam int IN_W = 9 * DATA_W;
  // output item width (4 x 16 bits)
  localparam int OUT_W = 4 * DATA_W;

  // Signed sum of three input elements plus ONE, for FRAC_BITS up to 30.
  localparam int RAD_W = 34;
  // Numerator: difference or sum of two elements.
  localparam int NUM_W = 17;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic              deg;
    logic              lead_w;
    logic [1:0]        ax;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } rmq_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd32767;
    lo = -64'sd32768;
    if (v > hi) sat16 = 16'sh7fff;
    else if (v < lo) sat16 = 16'sh8000;
    else sat16 = v[DATA_W-1:0];
  endfunction

endpackage

// ===== sv/rotation_matrix_to_quaternion.sv =====
// channel   dir  tdata                                 tuser
// s_axis    in   r00..r22, 16b each, r00 lowest        -
// m_axis    out  quat_x,quat_y,quat_z,quat_w           degenerate
//
// One item per cycle unless m_axis stalls; the path is registered in the front stage,
// the 4-bit-per-stage root and divider pipelines, and the output stage.
// rst clears valid bits only. A stall on m_axis freezes the whole pipe;
// s_axis_tready follows the output stage's free slot.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // quat_x,quat_y,quat_z,quat_w
  output logic              m_axis_tuser    // degenerate
);

  localparam int SW = (RAD_W + FRAC_BITS + 1) / 2;

  logic en;
  logic f_v, s_v, d_v;
  logic [RAD_W-1:0] f_rad;
  rmq_ctl_t f_ctl, s_ctl;
  logic [SW-1:0] s_root;
  logic [OUT_W-1:0] d_data;
  logic d_deg;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en,
    .in_valid(s_axis_tvalid), .in_data(s_axis_tdata),
    .out_valid(f_v), .rad(f_rad), .ctl(f_ctl)
  );

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_sqrt (
    .clk, .rst, .en,
    .in_valid(f_v), .rad(f_rad), .in_ctl(f_ctl),
    .out_valid(s_v), .root(s_root), .out_ctl(s_ctl)
  );

  rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
    .clk, .rst, .en,
    .in_valid(s_v), .root(s_root), .in_ctl(s_ctl),
    .out_valid(d_v), .out_data(d_data), .out_deg(d_deg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= d_v;
    end
    if (en) begin
      m_axis_tdata <= d_data;
      m_axis_tuser <= d_deg;
    end
  end

endmodule

// ===== sv/rmq_front.sv =====
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       in_data,
  output logic                  out_valid,
  output logic [RAD_W-1:0]      rad,
  output rmq_ctl_t              ctl
);

  logic signed [DATA_W-1:0] m [9];
  logic signed [RAD_W-1:0] tr, rad_c, one;
  logic [1:0] i_c;
  logic signed [DATA_W-1:0] rii, rjj, rkk;
  rmq_ctl_t ctl_c;

  always_comb begin
    for (int e = 0; e < 9; e++) m[e] = in_data[e*DATA_W +: DATA_W];
    one = RAD_W'(1) <<< FRAC_BITS;
    tr = RAD_W'(m[0]) + RAD_W'(m[4]) + RAD_W'(m[8]);
    if (m[0] < m[4]) i_c = (m[4] < m[8]) ? AX_Z : AX_Y;
    else i_c = (m[0] < m[8]) ? AX_Z : AX_X;
    ctl_c = '0;
    ctl_c.ax = i_c;
    case (i_c)
      AX_X: begin
        rii = m[0]; rjj = m[4]; rkk = m[8];
      end
      AX_Y: begin
        rii = m[4]; rjj = m[8]; rkk = m[0];
      end
      default: begin
        rii = m[8]; rjj = m[0]; rkk = m[4];
      end
    endcase
    if (tr > 0) begin
      ctl_c.lead_w = 1'b1;
      rad_c = tr + one;
      ctl_c.n0 = NUM_W'(m[7]) - NUM_W'(m[5]);
      ctl_c.n1 = NUM_W'(m[2]) - NUM_W'(m[6]);
      ctl_c.n2 = NUM_W'(m[3]) - NUM_W'(m[1]);
    end else begin
      rad_c = RAD_W'(rii) - RAD_W'(rjj) - RAD_W'(rkk) + one;
      ctl_c.deg = (rad_c <= 0);
      // n0: w, n1: q[j], n2: q[k]
      case (i_c)
        AX_X: begin
          ctl_c.n0 = NUM_W'(m[7]) - NUM_W'(m[5]);
          ctl_c.n1 = NUM_W'(m[3]) + NUM_W'(m[1]);
          ctl_c.n2 = NUM_W'(m[6]) + NUM_W'(m[2]);
        end
        AX_Y: begin
          ctl_c.n0 = NUM_W'(m[2]) - NUM_W'(m[6]);
          ctl_c.n1 = NUM_W'(m[7]) + NUM_W'(m[5]);
          ctl_c.n2 = NUM_W'(m[1]) + NUM_W'(m[3]);
        end
        default: begin
          ctl_c.n0 = NUM_W'(m[3]) - NUM_W'(m[1]);
          ctl_c.n1 = NUM_W'(m[2]) + NUM_W'(m[6]);
          ctl_c.n2 = NUM_W'(m[5]) + NUM_W'(m[7]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      rad <= ctl_c.deg ? '0 : rad_c;
      ctl <= ctl_c;
    end
  end

endmodule

// ===== sv/rmq_sqrt.sv =====
module rmq_sqrt import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SW = (RAD_W + FRAC_BITS + 1) / 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [RAD_W-1:0]      rad,
  input  rmq_ctl_t              in_ctl,
  output logic                  out_valid,
  output logic [SW-1:0]         root,
  output rmq_ctl_t              out_ctl
);

  localparam int XW = RAD_W + FRAC_BITS;
  localparam int BPS = 4;
  localparam int NST = (SW + BPS - 1) / BPS;
  localparam int TOT = NST * BPS;

  // one restoring root bit per step; BPS steps between registers
  logic [XW-1:0]   x_q  [NST+1];
  logic [XW+1:0]   r_q  [NST+1];
  logic [TOT-1:0]  s_q  [NST+1];
  logic            v_q  [NST+1];
  rmq_ctl_t        c_q  [NST+1];

  always_comb begin
    x_q[0] = XW'(rad) << FRAC_BITS;
    r_q[0] = '0;
    s_q[0] = '0;
    v_q[0] = in_valid;
    c_q[0] = in_ctl;
  end

  for (genvar g = 0; g < NST; g++) begin : g_st
    logic [XW+1:0]  r_c;
    logic [TOT-1:0] s_c;
    logic [XW+1:0]  t;
    logic [1:0]     pair;
    always_comb begin
      r_c = r_q[g];
      s_c = s_q[g];
      t = '0;
      pair = '0;
      for (int b = 0; b < BPS; b++) begin
        if ((TOT - 1 - (g*BPS + b)) * 2 + 1 < XW)
          pair[1] = x_q[g][(TOT - 1 - (g*BPS + b)) * 2 + 1];
        else
          pair[1] = 1'b0;
        if ((TOT - 1 - (g*BPS + b)) * 2 < XW)
          pair[0] = x_q[g][(TOT - 1 - (g*BPS + b)) * 2];
        else
          pair[0] = 1'b0;
        r_c = {r_c[XW-1:0], pair};
        t = {(XW+2-TOT)'(0), s_c[TOT-3:0], 2'b01};
        if (r_c >= t) begin
          r_c = r_c - t;
          s_c = {s_c[TOT-2:0], 1'b1};
        end else begin
          s_c = {s_c[TOT-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[g+1] <= 1'b0;
      end else if (en) begin
        v_q[g+1] <= v_q[g];
      end
      if (en) begin
        x_q[g+1] <= x_q[g];
        r_q[g+1] <= r_c;
        s_q[g+1] <= s_c;
        c_q[g+1] <= c_q[g];
      end
    end
  end

  assign out_valid = v_q[NST];
  assign root = s_q[NST][SW-1:0];
  assign out_ctl = c_q[NST];

endmodule

// ===== sv/rmq_div.sv =====
module rmq_div import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SW = (RAD_W + FRAC_BITS + 1) / 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [SW-1:0]         root,
  input  rmq_ctl_t              in_ctl,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_data,
  output logic                  out_deg
);

  // q = (2*|n|*2^F + 2s) / (4s); three lanes, restoring, BPS bits/stage
  localparam int NW = NUM_W + FRAC_BITS + 2;
  localparam int DW = SW + 2;
  localparam int BPS = 4;
  localparam int NST = (NW + BPS - 1) / BPS;
  localparam int TOT = NST * BPS;

  logic [NW-1:0]  n_q [3][NST+1];
  logic [DW:0]    r_q [3][NST+1];
  logic [TOT-1:0] q_q [3][NST+1];
  logic [DW-1:0]  d_q [NST+1];
  logic [SW-1:0]  s_q [NST+1];
  logic           v_q [NST+1];
  rmq_ctl_t       c_q [NST+1];

  logic [NUM_W-1:0] mag [3];
  logic signed [NUM_W-1:0] nsrc [3];

  always_comb begin
    nsrc[0] = in_ctl.n0;
    nsrc[1] = in_ctl.n1;
    nsrc[2] = in_ctl.n2;
    for (int l = 0; l < 3; l++) begin
      mag[l] = nsrc[l][NUM_W-1] ? NUM_W'(-nsrc[l]) : NUM_W'(nsrc[l]);
      n_q[l][0] = (NW'(mag[l]) << (FRAC_BITS + 1)) + (NW'(root) << 1);
      r_q[l][0] = '0;
      q_q[l][0] = '0;
    end
    d_q[0] = DW'(root) << 2;
    s_q[0] = root;
    v_q[0] = in_valid;
    c_q[0] = in_ctl;
  end

  for (genvar g = 0; g < NST; g++) begin : g_st
    for (genvar l = 0; l < 3; l++) begin : g_ln
      logic [DW:0]    r_c;
      logic [TOT-1:0] q_c;
      logic           nb;
      always_comb begin
        r_c = r_q[l][g];
        q_c = q_q[l][g];
        nb = 1'b0;
        for (int b = 0; b < BPS; b++) begin
          if (TOT - 1 - (g*BPS + b) < NW) nb = n_q[l][g][TOT - 1 - (g*BPS + b)];
          else nb = 1'b0;
          r_c = {r_c[DW-1:0], nb};
          if (r_c >= {1'b0, d_q[g]}) begin
            r_c = r_c - {1'b0, d_q[g]};
            q_c = {q_c[TOT-2:0], 1'b1};
          end else begin
            q_c = {q_c[TOT-2:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          n_q[l][g+1] <= n_q[l][g];
          r_q[l][g+1] <= r_c;
          q_q[l][g+1] <= q_c;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[g+1] <= 1'b0;
      end else if (en) begin
        v_q[g+1] <= v_q[g];
      end
      if (en) begin
        d_q[g+1] <= d_q[g];
        s_q[g+1] <= s_q[g];
        c_q[g+1] <= c_q[g];
      end
    end
  end

  logic signed [63:0] qv [3];
  logic signed [63:0] lead;
  logic signed [DATA_W-1:0] o [4];
  logic signed [NUM_W-1:0] nfin [3];
  rmq_ctl_t cf;

  always_comb begin
    cf = c_q[NST];
    nfin[0] = cf.n0;
    nfin[1] = cf.n1;
    nfin[2] = cf.n2;
    for (int l = 0; l < 3; l++) begin
      qv[l] = 64'(q_q[l][NST]);
      if (nfin[l][NUM_W-1]) qv[l] = -qv[l];
    end
    lead = 64'((65'(s_q[NST]) + 65'd1) >> 1);
    for (int c = 0; c < 4; c++) o[c] = '0;
    if (cf.lead_w) begin
      o[3] = sat16(lead);
      o[0] = sat16(qv[0]);
      o[1] = sat16(qv[1]);
      o[2] = sat16(qv[2]);
    end else if (!cf.deg) begin
      o[3] = sat16(qv[0]);
      case (cf.ax)
        AX_X: begin
          o[0] = sat16(lead); o[1] = sat16(qv[1]); o[2] = sat16(qv[2]);
        end
        AX_Y: begin
          o[1] = sat16(lead); o[2] = sat16(qv[1]); o[0] = sat16(qv[2]);
        end
        default: begin
          o[2] = sat16(lead); o[0] = sat16(qv[1]); o[1] = sat16(qv[2]);
        end
      endcase
    end
  end

  assign out_valid = v_q[NST];
  assign out_data = {o[3], o[2], o[1], o[0]};
  assign out_deg = cf.deg;

endmodule

// ===== sv/rmq_checker.sv =====
module rmq_checker import rmq_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item dropped or changed under stall");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate item with nonzero components");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk, .rst, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
